// ----- hdl/assert_macros.svh -----
// Assertion helpers used by the checker file.
// Each macro expects clk and arst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define VID_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define VID_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- hdl/vid_pkg.sv -----
package vid_pkg;

	localparam int TABLE_DEPTH_DEF = 1024;
	localparam int ATTR_DEPTH_DEF  = 1024;
	localparam int KEYS_PER_CELL   = 8;

	localparam int REF_W    = 10;
	localparam int KEY_W    = 3 * REF_W;
	localparam int WORD_W   = 32;
	localparam int ID_OUT_W = 10;

	localparam logic [2:0] ACT_LOAD_POS = 3'd0;
	localparam logic [2:0] ACT_LOAD_TEX = 3'd1;
	localparam logic [2:0] ACT_LOAD_NRM = 3'd2;
	localparam logic [2:0] ACT_FACE     = 3'd3;
	localparam logic [2:0] ACT_CLEAR    = 3'd4;

	localparam logic [1:0] ST_OK     = 2'd0;
	localparam logic [1:0] ST_FULL   = 2'd1;
	localparam logic [1:0] ST_BADREF = 2'd2;

	typedef enum logic [1:0] {
		S_IDLE,
		S_SEARCH,
		S_FINISH
	} ctrl_state_t;

	// Control bits of a probe walking the cell row.
	typedef struct packed {
		logic vld;
		logic hit;
	} probe_ctl_t;

endpackage

// ----- hdl/vid_attr_mem.sv -----
module vid_attr_mem #(
	parameter int WIDTH = vid_pkg::WORD_W,
	parameter int DEPTH = vid_pkg::ATTR_DEPTH_DEF
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);
	import vid_pkg::*;

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// Hold read data until the next read.
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

// ----- hdl/vid_cell.sv -----
module vid_cell #(
	parameter int TABLE_DEPTH = vid_pkg::TABLE_DEPTH_DEF,
	parameter int CELL_IDX    = 0
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  vid_pkg::probe_ctl_t                prev_ctl,
	input  logic [vid_pkg::KEY_W-1:0]          prev_key,
	input  logic [$clog2(TABLE_DEPTH+1)-1:0]   prev_rem,
	input  logic [$clog2(TABLE_DEPTH)-1:0]     prev_id,
	output vid_pkg::probe_ctl_t                next_ctl,
	output logic [vid_pkg::KEY_W-1:0]          next_key,
	output logic [$clog2(TABLE_DEPTH+1)-1:0]   next_rem,
	output logic [$clog2(TABLE_DEPTH)-1:0]     next_id,
	input  logic                               wr_en,
	input  logic [$clog2(TABLE_DEPTH)-1:0]     wr_id,
	input  logic [vid_pkg::KEY_W-1:0]          wr_key
);
	import vid_pkg::*;

	localparam int IDW    = $clog2(TABLE_DEPTH);
	localparam int CW     = $clog2(TABLE_DEPTH + 1);
	localparam int SLOT_W = $clog2(KEYS_PER_CELL);

	logic [KEY_W-1:0]  slot_key_q [KEYS_PER_CELL];
	probe_ctl_t        ctl_q;
	logic [KEY_W-1:0]  key_q;
	logic [CW-1:0]     rem_q;
	logic [IDW-1:0]    id_q;
	logic              hit_here;
	logic [SLOT_W-1:0] hit_slot;
	logic              wr_here;
	logic [SLOT_W-1:0] wr_slot;

	// Only slots below the remaining entry count take part; lowest slot wins.
	always_comb begin
		hit_here = 1'b0;
		hit_slot = '0;
		for (int j = KEYS_PER_CELL - 1; j >= 0; j--) begin
			if ((j < int'(prev_rem)) && (slot_key_q[j] == prev_key)) begin
				hit_here = 1'b1;
				hit_slot = SLOT_W'(j);
			end
		end
	end

	assign wr_here = wr_en && ((int'(wr_id) / KEYS_PER_CELL) == CELL_IDX);
	assign wr_slot = SLOT_W'(int'(wr_id) % KEYS_PER_CELL);

	always_ff @(posedge clk) begin
		if (wr_here) begin
			slot_key_q[wr_slot] <= wr_key;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_q <= '0;
		end else begin
			ctl_q.vld <= prev_ctl.vld;
			ctl_q.hit <= prev_ctl.hit || (prev_ctl.vld && hit_here);
		end
	end

	always_ff @(posedge clk) begin
		key_q <= prev_key;
		rem_q <= (int'(prev_rem) > KEYS_PER_CELL) ?
			CW'(int'(prev_rem) - KEYS_PER_CELL) : '0;
		id_q  <= prev_ctl.hit ? prev_id :
			IDW'(CELL_IDX * KEYS_PER_CELL + int'(hit_slot));
	end

	assign next_ctl = ctl_q;
	assign next_key = key_q;
	assign next_rem = rem_q;
	assign next_id  = id_q;

endmodule

// ----- hdl/vid_chain.sv -----
module vid_chain #(
	parameter int TABLE_DEPTH = vid_pkg::TABLE_DEPTH_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  vid_pkg::probe_ctl_t              head_ctl,
	input  logic [vid_pkg::KEY_W-1:0]        head_key,
	input  logic [$clog2(TABLE_DEPTH+1)-1:0] head_rem,
	output vid_pkg::probe_ctl_t              tail_ctl,
	output logic [$clog2(TABLE_DEPTH)-1:0]   tail_id,
	input  logic                             wr_en,
	input  logic [$clog2(TABLE_DEPTH)-1:0]   wr_id,
	input  logic [vid_pkg::KEY_W-1:0]        wr_key
);
	import vid_pkg::*;

	localparam int IDW   = $clog2(TABLE_DEPTH);
	localparam int CW    = $clog2(TABLE_DEPTH + 1);
	localparam int NCELL = (TABLE_DEPTH + KEYS_PER_CELL - 1) / KEYS_PER_CELL;

	probe_ctl_t       ctl [NCELL+1];
	logic [KEY_W-1:0] key [NCELL+1];
	logic [CW-1:0]    rem [NCELL+1];
	logic [IDW-1:0]   id  [NCELL+1];

	assign ctl[0] = head_ctl;
	assign key[0] = head_key;
	assign rem[0] = head_rem;
	assign id[0]  = '0;

	for (genvar c = 0; c < NCELL; c++) begin : g_cell
		vid_cell #(
			.TABLE_DEPTH(TABLE_DEPTH),
			.CELL_IDX   (c)
		) u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.prev_ctl(ctl[c]),
			.prev_key(key[c]),
			.prev_rem(rem[c]),
			.prev_id (id[c]),
			.next_ctl(ctl[c+1]),
			.next_key(key[c+1]),
			.next_rem(rem[c+1]),
			.next_id (id[c+1]),
			.wr_en   (wr_en),
			.wr_id   (wr_id),
			.wr_key  (wr_key)
		);
	end

	assign tail_ctl = ctl[NCELL];
	assign tail_id  = id[NCELL];

endmodule

// ----- hdl/vertex_index_dedup_top.sv -----
// Loads and clears may follow every cycle while no face corner is in progress (in_stall low).
// A face corner walks a row of ceil(TABLE_DEPTH/8) cells, eight keys compared per cell;
// its result goes through the cell registers and the finish state into the output register,
// and the next request is taken once the finish state has passed. A bad reference skips the walk.
// A result waiting in the output register does not hold off load or clear requests.
// Reset clears the four counts and the control state; stores stay undefined, no sweep.
module vertex_index_dedup_top #(
	parameter int TABLE_DEPTH = vid_pkg::TABLE_DEPTH_DEF,
	parameter int ATTR_DEPTH  = vid_pkg::ATTR_DEPTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [2:0]  action,
	input  logic [31:0] word_a,
	input  logic [31:0] word_b,
	input  logic [31:0] word_c,
	input  logic [9:0]  position_ref,
	input  logic [9:0]  texcoord_ref,
	input  logic [9:0]  normal_ref,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [9:0]  vertex_id,
	output logic        is_new,
	output logic [1:0]  status,
	output logic [31:0] pos_x,
	output logic [31:0] pos_y,
	output logic [31:0] pos_z,
	output logic [31:0] tex_u,
	output logic [31:0] tex_v,
	output logic [31:0] norm_x,
	output logic [31:0] norm_y,
	output logic [31:0] norm_z
);
	import vid_pkg::*;

	localparam int IDW = $clog2(TABLE_DEPTH);
	localparam int CW  = $clog2(TABLE_DEPTH + 1);
	localparam int AIW = $clog2(ATTR_DEPTH);
	localparam int AW  = $clog2(ATTR_DEPTH + 1);

	ctrl_state_t state_q, state_d;

	logic [AW-1:0] pos_cnt_q, tex_cnt_q, nrm_cnt_q;
	logic [CW-1:0] entry_cnt_q;

	logic accept;
	logic ld_pos, ld_tex, ld_nrm, face, clr;
	logic pos_wr, tex_wr, nrm_wr;
	logic bad_now, badref_q;
	logic [KEY_W-1:0] key_now, key_q;

	probe_ctl_t     head_ctl, tail_ctl;
	logic [IDW-1:0] tail_id;
	logic           hit_q;
	logic [IDW-1:0] hit_id_q;

	logic commit, out_free, tbl_full, tbl_wr;

	logic [3*WORD_W-1:0] pos_rd, nrm_rd;
	logic [2*WORD_W-1:0] tex_rd;

	logic [ID_OUT_W-1:0] res_id;
	logic                res_new;
	logic [1:0]          res_status;

	logic                out_valid_q;
	logic [ID_OUT_W-1:0] vertex_id_q;
	logic                is_new_q;
	logic [1:0]          status_q;
	logic [3*WORD_W-1:0] pos_q, nrm_q;
	logic [2*WORD_W-1:0] tex_q;

	assign in_stall = (state_q != S_IDLE);
	assign accept   = in_valid && !in_stall;

	always_comb begin
		ld_pos = 1'b0;
		ld_tex = 1'b0;
		ld_nrm = 1'b0;
		face   = 1'b0;
		clr    = 1'b0;
		unique case (action)
			ACT_LOAD_POS: ld_pos = accept;
			ACT_LOAD_TEX: ld_tex = accept;
			ACT_LOAD_NRM: ld_nrm = accept;
			ACT_FACE:     face   = accept;
			ACT_CLEAR:    clr    = accept;
			default: ;
		endcase
	end

	// Drop loads into a full store.
	assign pos_wr = ld_pos && (pos_cnt_q != AW'(ATTR_DEPTH));
	assign tex_wr = ld_tex && (tex_cnt_q != AW'(ATTR_DEPTH));
	assign nrm_wr = ld_nrm && (nrm_cnt_q != AW'(ATTR_DEPTH));

	assign bad_now = (int'(position_ref) >= int'(pos_cnt_q)) ||
		(int'(texcoord_ref) >= int'(tex_cnt_q)) ||
		(int'(normal_ref) >= int'(nrm_cnt_q));
	assign key_now = {normal_ref, texcoord_ref, position_ref};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_cnt_q   <= '0;
			tex_cnt_q   <= '0;
			nrm_cnt_q   <= '0;
			entry_cnt_q <= '0;
		end else if (clr) begin
			pos_cnt_q   <= '0;
			tex_cnt_q   <= '0;
			nrm_cnt_q   <= '0;
			entry_cnt_q <= '0;
		end else begin
			if (pos_wr) pos_cnt_q <= pos_cnt_q + AW'(1);
			if (tex_wr) tex_cnt_q <= tex_cnt_q + AW'(1);
			if (nrm_wr) nrm_cnt_q <= nrm_cnt_q + AW'(1);
			if (tbl_wr) entry_cnt_q <= entry_cnt_q + CW'(1);
		end
	end

	vid_attr_mem #(.WIDTH(3 * WORD_W), .DEPTH(ATTR_DEPTH)) u_pos_mem (
		.clk    (clk),
		.wr_en  (pos_wr),
		.wr_addr(pos_cnt_q[AIW-1:0]),
		.wr_data({word_c, word_b, word_a}),
		.rd_en  (face),
		.rd_addr(AIW'(position_ref)),
		.rd_data(pos_rd)
	);

	vid_attr_mem #(.WIDTH(2 * WORD_W), .DEPTH(ATTR_DEPTH)) u_tex_mem (
		.clk    (clk),
		.wr_en  (tex_wr),
		.wr_addr(tex_cnt_q[AIW-1:0]),
		.wr_data({word_b, word_a}),
		.rd_en  (face),
		.rd_addr(AIW'(texcoord_ref)),
		.rd_data(tex_rd)
	);

	vid_attr_mem #(.WIDTH(3 * WORD_W), .DEPTH(ATTR_DEPTH)) u_nrm_mem (
		.clk    (clk),
		.wr_en  (nrm_wr),
		.wr_addr(nrm_cnt_q[AIW-1:0]),
		.wr_data({word_c, word_b, word_a}),
		.rd_en  (face),
		.rd_addr(AIW'(normal_ref)),
		.rd_data(nrm_rd)
	);

	assign head_ctl = {face && !bad_now, 1'b0};

	vid_chain #(.TABLE_DEPTH(TABLE_DEPTH)) u_chain (
		.clk     (clk),
		.arst_n  (arst_n),
		.head_ctl(head_ctl),
		.head_key(key_now),
		.head_rem(entry_cnt_q),
		.tail_ctl(tail_ctl),
		.tail_id (tail_id),
		.wr_en   (tbl_wr),
		.wr_id   (entry_cnt_q[IDW-1:0]),
		.wr_key  (key_q)
	);

	always_ff @(posedge clk) begin
		if (face) begin
			key_q    <= key_now;
			badref_q <= bad_now;
		end
		if (tail_ctl.vld) begin
			hit_q    <= tail_ctl.hit;
			hit_id_q <= tail_id;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign out_free = !out_valid_q || !out_stall;
	assign tbl_full = (entry_cnt_q == CW'(TABLE_DEPTH));

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (face) state_d = bad_now ? S_FINISH : S_SEARCH;
			end
			S_SEARCH: begin
				if (tail_ctl.vld) state_d = S_FINISH;
			end
			S_FINISH: begin
				if (out_free) state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_comb begin
		commit = 1'b0;
		tbl_wr = 1'b0;
		unique case (state_q)
			S_FINISH: begin
				commit = out_free;
				tbl_wr = out_free && !badref_q && !hit_q && !tbl_full;
			end
			S_IDLE, S_SEARCH: ;
			default: ;
		endcase
	end

	always_comb begin
		res_id     = '0;
		res_new    = 1'b0;
		res_status = ST_OK;
		if (badref_q) begin
			res_status = ST_BADREF;
		end else if (hit_q) begin
			res_id = ID_OUT_W'(int'(hit_id_q));
		end else if (tbl_full) begin
			res_status = ST_FULL;
		end else begin
			res_id  = ID_OUT_W'(int'(entry_cnt_q));
			res_new = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (commit) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// Zero the attribute words unless a vertex was created.
	always_ff @(posedge clk) begin
		if (commit) begin
			vertex_id_q <= res_id;
			is_new_q    <= res_new;
			status_q    <= res_status;
			pos_q       <= res_new ? pos_rd : '0;
			tex_q       <= res_new ? tex_rd : '0;
			nrm_q       <= res_new ? nrm_rd : '0;
		end
	end

	assign out_valid = out_valid_q;
	assign vertex_id = vertex_id_q;
	assign is_new    = is_new_q;
	assign status    = status_q;
	assign pos_x     = pos_q[WORD_W-1:0];
	assign pos_y     = pos_q[2*WORD_W-1:WORD_W];
	assign pos_z     = pos_q[3*WORD_W-1:2*WORD_W];
	assign tex_u     = tex_q[WORD_W-1:0];
	assign tex_v     = tex_q[2*WORD_W-1:WORD_W];
	assign norm_x    = nrm_q[WORD_W-1:0];
	assign norm_y    = nrm_q[2*WORD_W-1:WORD_W];
	assign norm_z    = nrm_q[3*WORD_W-1:2*WORD_W];

endmodule

// ----- hdl/vid_checker.sv -----
`include "assert_macros.svh"

module vid_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_stall,
	input logic [2:0]  action,
	input logic [31:0] word_a,
	input logic [31:0] word_b,
	input logic [31:0] word_c,
	input logic [9:0]  position_ref,
	input logic [9:0]  texcoord_ref,
	input logic [9:0]  normal_ref,
	input logic        out_valid,
	input logic        out_stall,
	input logic [9:0]  vertex_id,
	input logic        is_new,
	input logic [1:0]  status,
	input logic [31:0] pos_x,
	input logic [31:0] pos_y,
	input logic [31:0] pos_z,
	input logic [31:0] tex_u,
	input logic [31:0] tex_v,
	input logic [31:0] norm_x,
	input logic [31:0] norm_y,
	input logic [31:0] norm_z
);
	import vid_pkg::*;

	`VID_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(vertex_id) && $stable(is_new) && $stable(status), "result changed while stalled")
	`VID_ASSERT_NOW(a_new_ok, out_valid && is_new, status == ST_OK, "new vertex with error status")
	`VID_ASSERT_NOW(a_err_zero, out_valid && (status != ST_OK), (vertex_id == 10'd0) && !is_new, "error result carries a vertex")
	`VID_ASSERT_NOW(a_old_no_attr, out_valid && !is_new, (pos_x == 32'd0) && (pos_y == 32'd0) && (pos_z == 32'd0) && (tex_u == 32'd0) && (tex_v == 32'd0) && (norm_x == 32'd0) && (norm_y == 32'd0) && (norm_z == 32'd0), "attributes without new vertex")

endmodule

bind vertex_index_dedup_top vid_checker u_vid_checker (.*);

// ----- sim/vertex_index_dedup_top_test.sv -----
`timescale 1ns / 1ps

module vertex_index_dedup_top_test;

	import vid_pkg::*;

	localparam logic [2:0] ACT_UNUSED_FIRST = 3'd5;
	localparam logic [2:0] ACT_UNUSED_LAST  = 3'd7;
	localparam int unsigned ITEM_BUDGET  = 2200;
	localparam int unsigned FILL_REFS    = 4;
	localparam int unsigned QUIET_LIMIT  = 2000;
	localparam int unsigned END_DRAIN    = 160;
	localparam int unsigned REF_MAX      = (1 << REF_W) - 1;

	typedef struct packed {
		logic [2:0]        action;
		logic [WORD_W-1:0] word_a;
		logic [WORD_W-1:0] word_b;
		logic [WORD_W-1:0] word_c;
		logic [REF_W-1:0]  position_ref;
		logic [REF_W-1:0]  texcoord_ref;
		logic [REF_W-1:0]  normal_ref;
	} corner_req_t;

	typedef struct packed {
		logic [ID_OUT_W-1:0] vertex_id;
		logic                is_new;
		logic [1:0]          status;
		logic [WORD_W-1:0]   pos_x;
		logic [WORD_W-1:0]   pos_y;
		logic [WORD_W-1:0]   pos_z;
		logic [WORD_W-1:0]   tex_u;
		logic [WORD_W-1:0]   tex_v;
		logic [WORD_W-1:0]   norm_x;
		logic [WORD_W-1:0]   norm_y;
		logic [WORD_W-1:0]   norm_z;
	} corner_result_t;

	class corner_scoreboard;
		logic [WORD_W-1:0] pos_words[3*ATTR_DEPTH_DEF];
		logic [WORD_W-1:0] tex_words[2*ATTR_DEPTH_DEF];
		logic [WORD_W-1:0] nrm_words[3*ATTR_DEPTH_DEF];
		logic [KEY_W-1:0]  keys[TABLE_DEPTH_DEF];
		int unsigned pos_count;
		int unsigned tex_count;
		int unsigned nrm_count;
		int unsigned entry_count;
		int unsigned errors;
		corner_result_t expected_corners[$];

		function void note_request(corner_req_t r);
			corner_result_t res;
			logic [KEY_W-1:0] key;
			int hit_at;
			int i;
			res = '0;
			case (r.action)
			ACT_LOAD_POS: begin
				if (pos_count < ATTR_DEPTH_DEF) begin
					pos_words[3*pos_count]     = r.word_a;
					pos_words[3*pos_count + 1] = r.word_b;
					pos_words[3*pos_count + 2] = r.word_c;
					pos_count++;
				end
			end
			ACT_LOAD_TEX: begin
				if (tex_count < ATTR_DEPTH_DEF) begin
					tex_words[2*tex_count]     = r.word_a;
					tex_words[2*tex_count + 1] = r.word_b;
					tex_count++;
				end
			end
			ACT_LOAD_NRM: begin
				if (nrm_count < ATTR_DEPTH_DEF) begin
					nrm_words[3*nrm_count]     = r.word_a;
					nrm_words[3*nrm_count + 1] = r.word_b;
					nrm_words[3*nrm_count + 2] = r.word_c;
					nrm_count++;
				end
			end
			ACT_CLEAR: begin
				pos_count   = 0;
				tex_count   = 0;
				nrm_count   = 0;
				entry_count = 0;
			end
			ACT_FACE: begin
				// reference check comes ahead of the search
				if (r.position_ref >= pos_count || r.texcoord_ref >= tex_count ||
						r.normal_ref >= nrm_count) begin
					res.status = ST_BADREF;
				end else begin
					key = {r.normal_ref, r.texcoord_ref, r.position_ref};
					hit_at = -1;
					for (i = 0; i < entry_count; i++)
						if (hit_at < 0 && keys[i] == key)
							hit_at = i;
					if (hit_at >= 0) begin
						res.vertex_id = ID_OUT_W'(hit_at);
					end else if (entry_count >= TABLE_DEPTH_DEF) begin
						res.status = ST_FULL;
					end else begin
						keys[entry_count] = key;
						res.vertex_id = ID_OUT_W'(entry_count);
						res.is_new = 1'b1;
						entry_count++;
						res.pos_x  = pos_words[3*r.position_ref];
						res.pos_y  = pos_words[3*r.position_ref + 1];
						res.pos_z  = pos_words[3*r.position_ref + 2];
						res.tex_u  = tex_words[2*r.texcoord_ref];
						res.tex_v  = tex_words[2*r.texcoord_ref + 1];
						res.norm_x = nrm_words[3*r.normal_ref];
						res.norm_y = nrm_words[3*r.normal_ref + 1];
						res.norm_z = nrm_words[3*r.normal_ref + 2];
					end
				end
				expected_corners.push_back(res);
			end
			default: ;
			endcase
		endfunction

		function void compare_field(string name, logic [WORD_W-1:0] want,
				logic [WORD_W-1:0] got);
			if (got !== want) begin
				$display("%0t: %s expected %h, got %h", $time, name, want, got);
				errors++;
			end
		endfunction

		function void check_corner(corner_result_t got);
			corner_result_t want;
			if (expected_corners.size() == 0) begin
				$display("%0t: unexpected result, expected none, got id %0d new %0b status %0d",
					$time, got.vertex_id, got.is_new, got.status);
				errors++;
			end else begin
				want = expected_corners.pop_front();
				compare_field("vertex_id", WORD_W'(want.vertex_id), WORD_W'(got.vertex_id));
				compare_field("is_new", WORD_W'(want.is_new), WORD_W'(got.is_new));
				compare_field("status", WORD_W'(want.status), WORD_W'(got.status));
				compare_field("pos_x", want.pos_x, got.pos_x);
				compare_field("pos_y", want.pos_y, got.pos_y);
				compare_field("pos_z", want.pos_z, got.pos_z);
				compare_field("tex_u", want.tex_u, got.tex_u);
				compare_field("tex_v", want.tex_v, got.tex_v);
				compare_field("norm_x", want.norm_x, got.norm_x);
				compare_field("norm_y", want.norm_y, got.norm_y);
				compare_field("norm_z", want.norm_z, got.norm_z);
			end
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	logic [2:0]  action;
	logic [31:0] word_a;
	logic [31:0] word_b;
	logic [31:0] word_c;
	logic [9:0]  position_ref;
	logic [9:0]  texcoord_ref;
	logic [9:0]  normal_ref;
	logic        out_valid;
	logic        out_stall;
	logic [9:0]  vertex_id;
	logic        is_new;
	logic [1:0]  status;
	logic [31:0] pos_x;
	logic [31:0] pos_y;
	logic [31:0] pos_z;
	logic [31:0] tex_u;
	logic [31:0] tex_v;
	logic [31:0] norm_x;
	logic [31:0] norm_y;
	logic [31:0] norm_z;

	corner_scoreboard sb = new;
	bit calm_in;
	bit calm_out;
	int unsigned quiet_cycles;
	int unsigned sent_items;
	int unsigned order[TABLE_DEPTH_DEF];

	vertex_index_dedup_top i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.action       (action),
		.word_a       (word_a),
		.word_b       (word_b),
		.word_c       (word_c),
		.position_ref (position_ref),
		.texcoord_ref (texcoord_ref),
		.normal_ref   (normal_ref),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.vertex_id    (vertex_id),
		.is_new       (is_new),
		.status       (status),
		.pos_x        (pos_x),
		.pos_y        (pos_y),
		.pos_z        (pos_z),
		.tex_u        (tex_u),
		.tex_v        (tex_v),
		.norm_x       (norm_x),
		.norm_y       (norm_y),
		.norm_z       (norm_z)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			sb.check_corner({vertex_id, is_new, status, pos_x, pos_y, pos_z,
				tex_u, tex_v, norm_x, norm_y, norm_z});
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			quiet_cycles <= 0;
		end else if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles == QUIET_LIMIT) begin
			$display("%0t: no progress for %0d cycles", $time, QUIET_LIMIT);
			$display("end of test: mismatches");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	function automatic int unsigned draw_wait(bit calm);
		return calm ? 0 : $urandom_range(0, 14);
	endfunction

	function automatic logic [31:0] rand_word();
		case ($urandom_range(0, 7))
		0: return '0;
		1: return '1;
		default: return $urandom;
		endcase
	endfunction

	function automatic corner_req_t random_req(logic [2:0] act);
		corner_req_t r;
		r.action       = act;
		r.word_a       = $urandom;
		r.word_b       = $urandom;
		r.word_c       = $urandom;
		r.position_ref = REF_W'($urandom);
		r.texcoord_ref = REF_W'($urandom);
		r.normal_ref   = REF_W'($urandom);
		return r;
	endfunction

	// entered and left at a falling edge
	task automatic send_request(input corner_req_t r);
		int unsigned gap;
		gap = draw_wait(calm_in);
		if (gap != 0) begin
			in_valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid     = 1'b1;
		action       = r.action;
		word_a       = r.word_a;
		word_b       = r.word_b;
		word_c       = r.word_c;
		position_ref = r.position_ref;
		texcoord_ref = r.texcoord_ref;
		normal_ref   = r.normal_ref;
		do @(posedge clk); while (in_stall);
		sb.note_request(r);
		sent_items++;
		@(negedge clk);
	endtask

	task automatic load_words(input logic [2:0] act, input logic [31:0] wa, wb, wc);
		corner_req_t r;
		r = random_req(act);
		r.word_a = wa;
		r.word_b = wb;
		r.word_c = wc;
		send_request(r);
	endtask

	task automatic face_corner(input int unsigned p, t, n);
		corner_req_t r;
		r = random_req(ACT_FACE);
		r.position_ref = REF_W'(p);
		r.texcoord_ref = REF_W'(t);
		r.normal_ref   = REF_W'(n);
		send_request(r);
	endtask

	task automatic clear_all();
		send_request(random_req(ACT_CLEAR));
	endtask

	task automatic load_mix(input int unsigned np, nt, nn);
		int unsigned pick;
		while (np + nt + nn != 0) begin
			pick = $urandom_range(0, 2);
			if (pick == 0 && np != 0) begin
				load_words(ACT_LOAD_POS, rand_word(), rand_word(), rand_word());
				np--;
			end else if (pick == 1 && nt != 0) begin
				load_words(ACT_LOAD_TEX, rand_word(), rand_word(), rand_word());
				nt--;
			end else if (pick == 2 && nn != 0) begin
				load_words(ACT_LOAD_NRM, rand_word(), rand_word(), rand_word());
				nn--;
			end
		end
	endtask

	// favor the first few entries so repeated corners hit
	function automatic int unsigned pick_ref(int unsigned cnt);
		if (cnt == 0)
			return $urandom_range(0, REF_MAX);
		if ($urandom_range(0, 1))
			return $urandom_range(0, (cnt < 4 ? cnt : 4) - 1);
		return $urandom_range(0, cnt - 1);
	endfunction

	function automatic int unsigned beyond_ref(int unsigned cnt);
		return $urandom_range(0, 1) ? cnt : $urandom_range(cnt, REF_MAX);
	endfunction

	task automatic bad_face();
		int unsigned which;
		int unsigned p;
		int unsigned t;
		int unsigned n;
		p = pick_ref(sb.pos_count);
		t = pick_ref(sb.tex_count);
		n = pick_ref(sb.nrm_count);
		which = $urandom_range(0, 3);
		if (which == 0 || which == 3)
			p = beyond_ref(sb.pos_count);
		if (which == 1 || which == 3)
			t = beyond_ref(sb.tex_count);
		if (which == 2 || which == 3)
			n = beyond_ref(sb.nrm_count);
		face_corner(p, t, n);
	endtask

	task automatic drain_results();
		int unsigned hold;
		forever begin
			if ($urandom_range(0, 31) == 0)
				calm_out = !calm_out;
			hold = draw_wait(calm_out);
			if (hold != 0) begin
				// half the time hold off until the result is already waiting
				if ($urandom_range(0, 1))
					do @(posedge clk); while (!out_valid);
				@(negedge clk);
				out_stall = 1'b1;
				repeat (hold) @(negedge clk);
				out_stall = 1'b0;
			end
			do @(posedge clk); while (!(out_valid && !out_stall));
		end
	endtask

	initial begin
		int unsigned k;
		int unsigned j;
		int unsigned tmp;
		int unsigned faces;
		int unsigned roll;
		logic [2:0] a;

		arst_n       = 1'b0;
		in_valid     = 1'b0;
		out_stall    = 1'b0;
		action       = ACT_CLEAR;
		word_a       = '0;
		word_b       = '0;
		word_c       = '0;
		position_ref = '0;
		texcoord_ref = '0;
		normal_ref   = '0;
		calm_in      = 1'b0;
		calm_out     = 1'b0;
		sent_items   = 0;
		repeat (10) @(negedge clk);
		arst_n = 1'b1;
		fork
			drain_results();
		join_none

		// directed: empty stores, extremes, hit and miss, each bad reference, spare codes
		face_corner(0, 0, 0);
		load_words(ACT_LOAD_POS, '0, '0, '0);
		load_words(ACT_LOAD_POS, '1, '1, '1);
		load_words(ACT_LOAD_TEX, '0, '1, 32'ha5a5_a5a5);
		load_words(ACT_LOAD_TEX, '1, '0, '1);
		load_words(ACT_LOAD_NRM, '1, '0, '1);
		load_words(ACT_LOAD_NRM, '0, '1, '0);
		face_corner(0, 0, 0);
		face_corner(1, 1, 1);
		face_corner(0, 0, 0);
		face_corner(2, 0, 0);
		face_corner(0, 2, 0);
		face_corner(0, 0, 2);
		face_corner(REF_MAX, REF_MAX, REF_MAX);
		for (a = ACT_UNUSED_FIRST; a <= ACT_UNUSED_LAST && a >= ACT_UNUSED_FIRST; a++)
			send_request(random_req(a));
		face_corner(1, 0, 1);
		face_corner(1, 1, 1);
		clear_all();
		face_corner(0, 0, 0);
		load_words(ACT_LOAD_POS, rand_word(), rand_word(), rand_word());
		load_words(ACT_LOAD_TEX, rand_word(), rand_word(), rand_word());
		load_words(ACT_LOAD_NRM, rand_word(), rand_word(), rand_word());
		face_corner(0, 0, 0);
		face_corner(0, 0, 0);

		// fill the position store past its depth, then fill the vertex table
		clear_all();
		load_mix(ATTR_DEPTH_DEF + 2, FILL_REFS, FILL_REFS);
		for (k = 0; k < TABLE_DEPTH_DEF; k++)
			order[k] = k;
		for (k = TABLE_DEPTH_DEF - 1; k > 0; k--) begin
			j = $urandom_range(0, k);
			tmp = order[k];
			order[k] = order[j];
			order[j] = tmp;
		end
		for (k = 0; k < TABLE_DEPTH_DEF; k++) begin
			if (k % 64 == 0)
				calm_in = ($urandom_range(0, 3) == 0);
			face_corner(order[k], order[k] % FILL_REFS, (order[k] / FILL_REFS) % FILL_REFS);
			if ($urandom_range(0, 31) == 0) begin
				j = order[$urandom_range(0, k)];
				face_corner(j, j % FILL_REFS, (j / FILL_REFS) % FILL_REFS);
			end
		end
		for (k = 0; k < 8; k++) begin
			j = $urandom_range(0, ATTR_DEPTH_DEF - 1);
			if (k % 2 == 0)
				face_corner(j, (j + 1) % FILL_REFS, (j / FILL_REFS) % FILL_REFS);
			else
				face_corner(j, j % FILL_REFS, (j / FILL_REFS) % FILL_REFS);
		end

		// random meshes: loads, then mostly well-formed corners with some noise
		while (sent_items < ITEM_BUDGET) begin
			calm_in = ($urandom_range(0, 3) == 0);
			if ($urandom_range(0, 3) != 0 || sb.pos_count > 1000 || sb.tex_count > 1000 ||
					sb.nrm_count > 1000)
				clear_all();
			j   = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 8);
			k   = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 8);
			tmp = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 8);
			load_mix(j, k, tmp);
			faces = $urandom_range(4, 30);
			repeat (faces) begin
				roll = $urandom_range(0, 15);
				if (roll == 0)
					send_request(random_req(3'($urandom_range(ACT_UNUSED_FIRST,
						ACT_UNUSED_LAST))));
				else if (roll == 1)
					bad_face();
				else if (roll == 2)
					load_mix($urandom_range(0, 1), $urandom_range(0, 1),
						$urandom_range(0, 1));
				else
					face_corner(pick_ref(sb.pos_count), pick_ref(sb.tex_count),
						pick_ref(sb.nrm_count));
			end
		end
		in_valid = 1'b0;

		while (sb.expected_corners.size() != 0)
			@(posedge clk);
		repeat (END_DRAIN) @(posedge clk);
		if (sb.errors == 0 && sb.expected_corners.size() == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule

// ----- vertex_index_dedup_top.f -----
+incdir+hdl
hdl/vid_pkg.sv
hdl/vid_attr_mem.sv
hdl/vid_cell.sv
hdl/vid_chain.sv
hdl/vertex_index_dedup_top.sv
hdl/vid_checker.sv
sim/vertex_index_dedup_top_test.sv
